>>> sv/cfmae_pkg.sv
// Shared types, constants and the microcode program of the cubic-fit error scorer.
// Depends on nothing; every other file imports it.
package cfmae_pkg;

  // Field and register widths.
  localparam int COORD_W   = 20;   // signed Q12.8 point coordinates
  localparam int COEF_W    = 48;   // signed Q8.40 coefficients
  localparam int NUM_COEF  = 4;
  localparam int CFG_IDX_W = 8;
  localparam int RES_W     = 20;   // unsigned Q12.8 result
  localparam int SUM_W     = 40;
  localparam int MAX_POINTS = 1024;
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int D_W       = $clog2(MAX_POINTS + 2);
  localparam int NUM_W     = SUM_W + 1;
  localparam int DCNT_W    = $clog2(NUM_W + 1);
  localparam int K_W       = $clog2(NUM_COEF);

  // Horner accumulator: signed, held within +-(2^62 - 1).
  localparam int ACC_W     = 63;
  localparam int MAG_W     = ACC_W - 1;
  localparam int WIDE_W    = 64;
  localparam int FRAC_X    = 8;
  localparam int LO_W      = 32;
  localparam int HI_W      = MAG_W - LO_W;
  localparam int HI_SHIFT  = LO_W - FRAC_X;
  localparam int PHI_OK_W  = MAG_W - HI_SHIFT;
  localparam int MUL_P_W   = LO_W + COORD_W;
  localparam int PLO_W     = MUL_P_W + 1;
  localparam int PHI_W     = HI_W + COORD_W;

  localparam logic signed [ACC_W-1:0]  ACC_POS = {1'b0, {MAG_W{1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_NEG = -ACC_POS;
  localparam logic signed [WIDE_W-1:0] LIM_POS = WIDE_W'(ACC_POS);
  localparam logic signed [WIDE_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic [RES_W-1:0]         RES_MAX = '1;
  localparam logic [WIDE_W-1:0]        HALF_LSB = WIDE_W'(1) << (LO_W - 1);
  localparam logic [PLO_W-1:0]         MUL_RND = PLO_W'(1) << (FRAC_X - 1);

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OP_NOP, OP_WAIT, OP_MAG, OP_MUL_LO, OP_MUL_HI, OP_SCALE, OP_ADD_COEF,
    OP_RESID, OP_RES_MAG, OP_ROUND, OP_ACCUM, OP_DIV_INIT, OP_DIV_STEP,
    OP_EMIT, OP_FULL
  } op_e;

  // Branch conditions: when true the sequencer jumps to the target step.
  typedef enum logic [2:0] {
    BR_NEXT, BR_ALWAYS, BR_NO_INPUT, BR_FULL, BR_LOOP, BR_NOT_LAST,
    BR_DIV_MORE, BR_OUT_BUSY
  } br_e;

  localparam int PC_W = 4;

  typedef struct packed {
    op_e             op;
    br_e             br;
    logic [PC_W-1:0] target;
  } uop_t;

  typedef struct packed {
    logic full;
    logic last;
    logic loop_more;
    logic div_more;
  } dp_status_t;

  typedef struct packed {
    logic [RES_W-1:0] mean_error;
    logic             saturated;
  } res_t;

  // Program addresses.
  localparam logic [PC_W-1:0] ST_WAIT     = PC_W'(0);
  localparam logic [PC_W-1:0] ST_MAG      = PC_W'(1);
  localparam logic [PC_W-1:0] ST_MUL_LO   = PC_W'(2);
  localparam logic [PC_W-1:0] ST_MUL_HI   = PC_W'(3);
  localparam logic [PC_W-1:0] ST_SCALE    = PC_W'(4);
  localparam logic [PC_W-1:0] ST_ADD_COEF = PC_W'(5);
  localparam logic [PC_W-1:0] ST_RESID    = PC_W'(6);
  localparam logic [PC_W-1:0] ST_RES_MAG  = PC_W'(7);
  localparam logic [PC_W-1:0] ST_ROUND    = PC_W'(8);
  localparam logic [PC_W-1:0] ST_ACCUM    = PC_W'(9);
  localparam logic [PC_W-1:0] ST_DIV_INIT = PC_W'(10);
  localparam logic [PC_W-1:0] ST_DIV_STEP = PC_W'(11);
  localparam logic [PC_W-1:0] ST_EMIT     = PC_W'(12);
  localparam logic [PC_W-1:0] ST_RESTART  = PC_W'(13);
  localparam logic [PC_W-1:0] ST_FULL     = PC_W'(14);
  localparam logic [PC_W-1:0] ST_TO_DIV   = PC_W'(15);

  // The control store. Each step names its operation and its branch.
  function automatic uop_t rom_word(input logic [PC_W-1:0] addr);
    uop_t w;
    unique case (addr)
      ST_WAIT:     w = '{op: OP_WAIT,     br: BR_NO_INPUT, target: ST_WAIT};
      ST_MAG:      w = '{op: OP_MAG,      br: BR_FULL,     target: ST_FULL};
      ST_MUL_LO:   w = '{op: OP_MUL_LO,   br: BR_NEXT,     target: ST_WAIT};
      ST_MUL_HI:   w = '{op: OP_MUL_HI,   br: BR_NEXT,     target: ST_WAIT};
      ST_SCALE:    w = '{op: OP_SCALE,    br: BR_NEXT,     target: ST_WAIT};
      ST_ADD_COEF: w = '{op: OP_ADD_COEF, br: BR_LOOP,     target: ST_MAG};
      ST_RESID:    w = '{op: OP_RESID,    br: BR_NEXT,     target: ST_WAIT};
      ST_RES_MAG:  w = '{op: OP_RES_MAG,  br: BR_NEXT,     target: ST_WAIT};
      ST_ROUND:    w = '{op: OP_ROUND,    br: BR_NEXT,     target: ST_WAIT};
      ST_ACCUM:    w = '{op: OP_ACCUM,    br: BR_NOT_LAST, target: ST_WAIT};
      ST_DIV_INIT: w = '{op: OP_DIV_INIT, br: BR_NEXT,     target: ST_WAIT};
      ST_DIV_STEP: w = '{op: OP_DIV_STEP, br: BR_DIV_MORE, target: ST_DIV_STEP};
      ST_EMIT:     w = '{op: OP_EMIT,     br: BR_OUT_BUSY, target: ST_EMIT};
      ST_RESTART:  w = '{op: OP_NOP,      br: BR_ALWAYS,   target: ST_WAIT};
      ST_FULL:     w = '{op: OP_FULL,     br: BR_NOT_LAST, target: ST_WAIT};
      ST_TO_DIV:   w = '{op: OP_NOP,      br: BR_ALWAYS,   target: ST_DIV_INIT};
      default:     w = '{op: OP_NOP,      br: BR_ALWAYS,   target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> sv/cfmae_point_if.sv
// Point channel: one detected point per item, with valid/ready handshake.
// Depends on cfmae_pkg for the coordinate width.
interface cfmae_point_if import cfmae_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

>>> sv/cfmae_result_if.sv
// Result channel: one mean-error item per point list, with valid/ready handshake.
// Depends on cfmae_pkg for the result width.
interface cfmae_result_if import cfmae_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] mean_error;
  logic             saturated;

  modport source (output valid, mean_error, saturated, input ready);
  modport sink   (input valid, mean_error, saturated, output ready);
endinterface

>>> sv/cfmae_cfg_if.sv
// Configuration write channel: register index and write data with valid/ready.
// Depends on cfmae_pkg for the index and data widths.
interface cfmae_cfg_if import cfmae_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/cubic_fit_mean_abs_error_top.sv
// Scores a cubic lane fit y = c0 + c1*x + c2*x^2 + c3*x^3 against a list of points arriving
// one per item; on the item flagged last_point it returns the rounded mean absolute
// residual in unsigned Q12.8 with a saturation flag, then starts a new list. Coefficients
// are signed Q8.40 registers 0 to 3 on the configuration channel; other indexes are ignored.
// A microcoded sequencer drives one shared 32x20 multiplier, so each point passes through
// the wait step, three Horner passes of five steps through that multiplier and four steps
// for the residual and the sum before the next point can be accepted. A last point then
// adds one step to set up the division, 41 restoring division steps, one to hand the item
// to the output register and one to return to the wait step. The
// hand-over stalls only while the output register still holds an earlier result; it holds
// the result while the next list is already being accepted. Once 1024 points have been
// counted, further points are only flagged.
// Depends on cfmae_pkg, the three channel interfaces, cfmae_sequencer and cfmae_datapath.
module cubic_fit_mean_abs_error_top import cfmae_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  cfmae_cfg_if.sink      cfg_i,
  cfmae_point_if.sink    point_i,
  cfmae_result_if.source result_o
);

  logic [NUM_COEF-1:0][COEF_W-1:0] coef_q;
  uop_t       uop;
  dp_status_t status;
  logic       in_fire;
  logic       out_busy;
  logic       emit;
  res_t       res;
  logic       out_valid_q;
  res_t       out_q;

  // Coefficient registers; writes to unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(NUM_COEF))) begin
      coef_q[cfg_i.index[K_W-1:0]] <= cfg_i.data;
    end
  end

  // A point item is taken only in the wait step of the program.
  assign point_i.ready = (uop.op == OP_WAIT);
  assign in_fire       = point_i.valid && point_i.ready;

  // Output register parts the result channel from the sequencer.
  assign out_busy = out_valid_q && !result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.mean_error = out_q.mean_error;
  assign result_o.saturated  = out_q.saturated;

  cfmae_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (point_i.valid),
    .out_busy_i (out_busy),
    .status_i   (status),
    .uop_o      (uop)
  );

  cfmae_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .uop_i        (uop),
    .in_fire_i    (in_fire),
    .point_x_i    (point_i.point_x),
    .point_y_i    (point_i.point_y),
    .last_point_i (point_i.last_point),
    .coef_i       (coef_q),
    .out_busy_i   (out_busy),
    .status_o     (status),
    .emit_o       (emit),
    .res_o        (res)
  );

endmodule

>>> sv/cfmae_sequencer.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on cfmae_pkg for the program and the control word types.
module cfmae_sequencer import cfmae_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_busy_i,
  input  dp_status_t status_i,
  output uop_t       uop_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  uop_t            uop;
  logic            taken;

  // Fetch the control word of the current step.
  assign uop   = rom_word(pc_q);
  assign uop_o = uop;

  // Evaluate the branch condition of this step.
  always_comb begin
    unique case (uop.br)
      BR_NEXT:     taken = 1'b0;
      BR_ALWAYS:   taken = 1'b1;
      BR_NO_INPUT: taken = !in_valid_i;
      BR_FULL:     taken = status_i.full;
      BR_LOOP:     taken = status_i.loop_more;
      BR_NOT_LAST: taken = !status_i.last;
      BR_DIV_MORE: taken = status_i.div_more;
      BR_OUT_BUSY: taken = out_busy_i;
      default:     taken = 1'b0;
    endcase
  end

  assign pc_d = taken ? uop.target : pc_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> sv/cfmae_datapath.sv
// Datapath of the scorer: shared 32x20 multiplier, Horner accumulator, residual
// rounding, running sum and count, and a one-bit-per-step restoring divider.
// Depends on cfmae_pkg; driven by the control word from cfmae_sequencer.
module cfmae_datapath import cfmae_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  uop_t                             uop_i,
  input  logic                             in_fire_i,
  input  logic signed [COORD_W-1:0]        point_x_i,
  input  logic signed [COORD_W-1:0]        point_y_i,
  input  logic                             last_point_i,
  input  logic [NUM_COEF-1:0][COEF_W-1:0]  coef_i,
  input  logic                             out_busy_i,
  output dp_status_t                       status_o,
  output logic                             emit_o,
  output res_t                             res_o
);

  // Per-item working registers.
  logic signed [COORD_W-1:0] y_q, y_d;
  logic                      last_q, last_d;
  logic [COORD_W-1:0]        xmag_q, xmag_d;
  logic                      xneg_q, xneg_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [MAG_W-1:0]          amag_q, amag_d;
  logic                      neg_q, neg_d;
  logic [PLO_W-1:0]          plo_q, plo_d;
  logic [PHI_W-1:0]          phi_q, phi_d;
  logic [WIDE_W-1:0]         diff_q, diff_d;
  logic [RES_W-1:0]          res_q, res_d;
  logic [NUM_W-1:0]          nq_q, nq_d;
  logic [D_W-1:0]            rem_q, rem_d;

  // Control and accumulated state.
  logic [K_W-1:0]            k_q, k_d;
  logic [DCNT_W-1:0]         dcnt_q, dcnt_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      ovf_q, ovf_d;

  // Combinational helpers.
  logic [COORD_W-1:0]        x_raw;
  logic [COORD_W-1:0]        x_mag;
  logic [ACC_W-1:0]          acc_raw;
  logic [ACC_W-1:0]          acc_inv;
  logic [LO_W-1:0]           mul_a;
  logic [MUL_P_W-1:0]        prod;
  logic                      hi_over;
  logic [ACC_W-1:0]          smag;
  logic [ACC_W-1:0]          smag_c;
  logic [COEF_W-1:0]         coef_sel;
  logic [COEF_W-1:0]         coef_top;
  logic signed [WIDE_W-1:0]  csum;
  logic signed [WIDE_W-1:0]  y_wide;
  logic [WIDE_W-1:0]         rnd;
  logic [LO_W-1:0]           rq;
  logic [NUM_W-1:0]          ssum;
  logic [D_W-1:0]            divisor;
  logic [D_W+1:0]            trial;
  logic                      ge;
  logic                      mean_over;

  // Magnitude and sign of the incoming x.
  assign x_raw = point_x_i;
  assign x_mag = x_raw[COORD_W-1] ? (~x_raw + 1'b1) : x_raw;

  // Magnitude of the accumulator for the next multiplication.
  assign acc_raw = acc_q;
  assign acc_inv = ~acc_raw + 1'b1;

  // Shared multiplier: low 32 bits or high 30 bits of |acc| times |x|.
  assign mul_a = (uop_i.op == OP_MUL_HI) ? LO_W'(amag_q[MAG_W-1:LO_W]) : amag_q[LO_W-1:0];
  assign prod  = MUL_P_W'(mul_a) * MUL_P_W'(xmag_q);

  // Recombine the partial products: (hi << 24) + (lo >> 8), saturating.
  assign hi_over = |phi_q[PHI_W-1:PHI_OK_W];
  assign smag    = ACC_W'({phi_q[PHI_OK_W-1:0], {HI_SHIFT{1'b0}}})
                 + ACC_W'(plo_q[PLO_W-1:FRAC_X]);
  assign smag_c  = (hi_over || smag[ACC_W-1]) ? ACC_W'(ACC_POS) : smag;

  // Coefficient addition, widened so the sum cannot wrap.
  assign coef_sel = coef_i[k_q];
  assign coef_top = coef_i[NUM_COEF-1];
  assign csum = $signed({acc_q[ACC_W-1], acc_q})
              + $signed({{(WIDE_W-COEF_W){coef_sel[COEF_W-1]}}, coef_sel});

  // Residual against y scaled to Q.40, then round to Q12.8.
  assign y_wide = $signed({{(WIDE_W-COORD_W-LO_W){y_q[COORD_W-1]}}, y_q, {LO_W{1'b0}}});
  assign rnd    = diff_q + HALF_LSB;
  assign rq     = rnd[WIDE_W-1:LO_W];

  // Running sum with one spare bit for the overflow check.
  assign ssum = {1'b0, sum_q} + NUM_W'(res_q);

  // Divider: divisor is count plus one; one quotient bit per step.
  assign divisor = D_W'(cnt_q) + 1'b1;
  assign trial   = {1'b0, rem_q, nq_q[NUM_W-1]} - {2'b0, divisor};
  assign ge      = !trial[D_W+1];

  assign mean_over = |nq_q[NUM_W-1:RES_W];

  // Status to the sequencer.
  assign status_o.full      = (cnt_q >= CNT_W'(MAX_POINTS));
  assign status_o.last      = last_q;
  assign status_o.loop_more = (k_q != '0);
  assign status_o.div_more  = (dcnt_q != DCNT_W'(1));

  // The result leaves only when the output register can take it.
  assign emit_o           = (uop_i.op == OP_EMIT) && !out_busy_i;
  assign res_o.mean_error = mean_over ? RES_MAX : nq_q[RES_W-1:0];
  assign res_o.saturated  = ovf_q || mean_over;

  // Operation decoder.
  always_comb begin
    y_d    = y_q;
    last_d = last_q;
    xmag_d = xmag_q;
    xneg_d = xneg_q;
    acc_d  = acc_q;
    amag_d = amag_q;
    neg_d  = neg_q;
    plo_d  = plo_q;
    phi_d  = phi_q;
    diff_d = diff_q;
    res_d  = res_q;
    nq_d   = nq_q;
    rem_d  = rem_q;
    k_d    = k_q;
    dcnt_d = dcnt_q;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    unique case (uop_i.op)
      OP_NOP: begin
      end
      OP_WAIT: begin
        if (in_fire_i) begin
          y_d    = point_y_i;
          last_d = last_point_i;
          xmag_d = x_mag;
          xneg_d = x_raw[COORD_W-1];
          acc_d  = $signed({{(ACC_W-COEF_W){coef_top[COEF_W-1]}}, coef_top});
          k_d    = K_W'(NUM_COEF - 2);
        end
      end
      OP_MAG: begin
        amag_d = acc_raw[ACC_W-1] ? acc_inv[MAG_W-1:0] : acc_raw[MAG_W-1:0];
        neg_d  = acc_raw[ACC_W-1] ^ xneg_q;
      end
      OP_MUL_LO: begin
        plo_d = PLO_W'(prod) + MUL_RND;
      end
      OP_MUL_HI: begin
        phi_d = prod[PHI_W-1:0];
      end
      OP_SCALE: begin
        if (hi_over || smag[ACC_W-1]) begin
          ovf_d = 1'b1;
        end
        acc_d = neg_q ? $signed(~smag_c + 1'b1) : $signed(smag_c);
      end
      OP_ADD_COEF: begin
        if (csum > LIM_POS) begin
          acc_d = ACC_POS;
          ovf_d = 1'b1;
        end else if (csum < LIM_NEG) begin
          acc_d = ACC_NEG;
          ovf_d = 1'b1;
        end else begin
          acc_d = csum[ACC_W-1:0];
        end
        k_d = k_q - 1'b1;
      end
      OP_RESID: begin
        diff_d = $signed({acc_q[ACC_W-1], acc_q}) - y_wide;
      end
      OP_RES_MAG: begin
        diff_d = diff_q[WIDE_W-1] ? (~diff_q + 1'b1) : diff_q;
      end
      OP_ROUND: begin
        if (|rq[LO_W-1:RES_W]) begin
          res_d = RES_MAX;
          ovf_d = 1'b1;
        end else begin
          res_d = rq[RES_W-1:0];
        end
      end
      OP_ACCUM: begin
        if (ssum[NUM_W-1]) begin
          sum_d = '1;
          ovf_d = 1'b1;
        end else begin
          sum_d = ssum[SUM_W-1:0];
        end
        cnt_d = cnt_q + 1'b1;
      end
      OP_DIV_INIT: begin
        nq_d   = {1'b0, sum_q} + NUM_W'(divisor >> 1);
        rem_d  = '0;
        dcnt_d = DCNT_W'(NUM_W);
      end
      OP_DIV_STEP: begin
        rem_d  = ge ? trial[D_W-1:0] : {rem_q[D_W-2:0], nq_q[NUM_W-1]};
        nq_d   = {nq_q[NUM_W-2:0], ge};
        dcnt_d = dcnt_q - 1'b1;
      end
      OP_EMIT: begin
        // Clear the list state once the result has been handed over.
        if (!out_busy_i) begin
          sum_d = '0;
          cnt_d = '0;
          ovf_d = 1'b0;
        end
      end
      OP_FULL: begin
        ovf_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Accumulated and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      dcnt_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      k_q    <= k_d;
      dcnt_q <= dcnt_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      last_q <= last_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    xmag_q <= xmag_d;
    xneg_q <= xneg_d;
    acc_q  <= acc_d;
    amag_q <= amag_d;
    neg_q  <= neg_d;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    diff_q <= diff_d;
    res_q  <= res_d;
    nq_q   <= nq_d;
    rem_q  <= rem_d;
  end

endmodule
